### rtl/core/qte_pkg.sv
package qte_pkg;

   // product sums: 2*(ab+cd) at scale 2^30 needs 34 signed bits
   localparam int SUM_W  = 34;
   // CORDIC vector width: magnitude grows by about 1.65 over sqrt(2)*2^32
   localparam int VEC_W  = 38;
   // angle accumulator at scale 2^24, covers pi plus the sum of the table
   localparam int ANG_W  = 28;
   // radicand 2^60 - s^2 and its floor square root
   localparam int RAD_W  = 61;
   localparam int ROOT_W = 31;
   // sine kept for pitch once the clamp has been split off
   localparam int SIN_W  = 31;
   localparam int OUT_W  = 16;
   localparam int ATAN_LEN = 24;

   localparam logic signed [ANG_W-1:0] PI_Q24      = 28'sd52707179;
   localparam int                      PI_Q13      = 25736;
   localparam int                      HALF_PI_Q13 = 12868;

   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic signed [VEC_W-1:0]  vec_type;
   typedef logic signed [ANG_W-1:0]  ang_type;
   typedef logic signed [OUT_W-1:0]  angle_type;
   typedef logic [RAD_W-1:0]         rad_type;
   typedef logic [ROOT_W-1:0]        root_type;

   // pitch sideband carried beside the square root
   typedef struct packed {
      logic signed [SIN_W-1:0] sine;
      logic                    clamp_pos;
      logic                    clamp_neg;
   } pitch_side_type;

   // round(atan(2^-i) * 2^24)
   function automatic ang_type atan_entry(input int idx);
      ang_type v;
      case (idx)
         0:  v = 28'sd13176795;
         1:  v = 28'sd7778716;
         2:  v = 28'sd4110060;
         3:  v = 28'sd2086331;
         4:  v = 28'sd1047214;
         5:  v = 28'sd524117;
         6:  v = 28'sd262123;
         7:  v = 28'sd131069;
         8:  v = 28'sd65536;
         9:  v = 28'sd32768;
         10: v = 28'sd16384;
         11: v = 28'sd8192;
         12: v = 28'sd4096;
         13: v = 28'sd2048;
         14: v = 28'sd1024;
         15: v = 28'sd512;
         16: v = 28'sd256;
         17: v = 28'sd128;
         18: v = 28'sd64;
         19: v = 28'sd32;
         20: v = 28'sd16;
         21: v = 28'sd8;
         22: v = 28'sd4;
         23: v = 28'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### rtl/core/quaternion_to_euler_angles.sv
// Quaternion to ZYX Euler angles, fully pipelined.
// The pitch path is the longest one, through these registers in order:
// products, sums, square, radicand, 31 square-root stages, CORDIC of CORDIC_ITERATIONS+2 stages.
// Throughput: one transfer per cycle; a stalled result freezes the whole pipeline.
// Reset: synchronous, clears the valid bits only; no clearing pass.
module quaternion_to_euler_angles import qte_pkg::*; #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_quat_w,
   input  logic signed [15:0]  req_quat_x,
   input  logic signed [15:0]  req_quat_y,
   input  logic signed [15:0]  req_quat_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_roll_angle,
   output logic signed [14:0]  rsp_pitch_angle,
   output logic signed [15:0]  rsp_yaw_angle,
   output logic                rsp_pitch_clamped
);

   localparam int CLAT = CORDIC_ITERATIONS + 2;
   localparam int DLY  = 2 + ROOT_W;
   localparam int LAT  = 2 + DLY + CLAT;
   localparam logic signed [SUM_W-1:0] ONE_Q30 = SUM_W'(64'sd1 << 30);

   logic advance;
   logic vld_ff [0:LAT-1];

   // hold everything while a result waits
   assign advance   = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // products
   logic signed [31:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         wx_ff <= req_quat_w * req_quat_x;
         yz_ff <= req_quat_y * req_quat_z;
         xx_ff <= req_quat_x * req_quat_x;
         yy_ff <= req_quat_y * req_quat_y;
         wy_ff <= req_quat_w * req_quat_y;
         zx_ff <= req_quat_z * req_quat_x;
         wz_ff <= req_quat_w * req_quat_z;
         xy_ff <= req_quat_x * req_quat_y;
         zz_ff <= req_quat_z * req_quat_z;
      end
   end

   // sine and cosine terms
   sum_type sr_ff, cr_ff, sp_ff, sy_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         sr_ff <= (SUM_W'(wx_ff) + SUM_W'(yz_ff)) <<< 1;
         cr_ff <= ONE_Q30 - ((SUM_W'(xx_ff) + SUM_W'(yy_ff)) <<< 1);
         sp_ff <= (SUM_W'(wy_ff) - SUM_W'(zx_ff)) <<< 1;
         sy_ff <= (SUM_W'(wz_ff) + SUM_W'(xy_ff)) <<< 1;
         cy_ff <= ONE_Q30 - ((SUM_W'(yy_ff) + SUM_W'(zz_ff)) <<< 1);
      end
   end

   // pitch: square of the sine, clamp detect, radicand
   logic signed [SIN_W-1:0]   sin_trunc;
   logic signed [2*SIN_W-1:0] s2_ff;
   pitch_side_type            ps3_ff, ps4_ff;
   rad_type                   rad_ff;

   assign sin_trunc = sp_ff[SIN_W-1:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ff            <= sin_trunc * sin_trunc;
         ps3_ff.sine      <= sin_trunc;
         ps3_ff.clamp_pos <= sp_ff >= ONE_Q30;
         ps3_ff.clamp_neg <= sp_ff <= -ONE_Q30;
         rad_ff           <= (rad_type'(1) << (RAD_W - 1)) - rad_type'(s2_ff[RAD_W-1:0]);
         ps4_ff           <= ps3_ff;
      end
   end

   root_type       root;
   pitch_side_type ps_sq;

   qte_isqrt u_isqrt (
      .clock    (clock),
      .en       (advance),
      .rad      (rad_ff),
      .side_in  (ps4_ff),
      .root     (root),
      .side_out (ps_sq)
   );

   angle_type roll_c, yaw_c, pitch_c;

   qte_cordic #(.ITER(CORDIC_ITERATIONS), .LIM(PI_Q13)) u_roll (
      .clock (clock),
      .en    (advance),
      .ya    (sr_ff),
      .xa    (cr_ff),
      .angle (roll_c)
   );

   qte_cordic #(.ITER(CORDIC_ITERATIONS), .LIM(PI_Q13)) u_yaw (
      .clock (clock),
      .en    (advance),
      .ya    (sy_ff),
      .xa    (cy_ff),
      .angle (yaw_c)
   );

   qte_cordic #(.ITER(CORDIC_ITERATIONS), .LIM(HALF_PI_Q13)) u_pitch (
      .clock (clock),
      .en    (advance),
      .ya    (SUM_W'(ps_sq.sine)),
      .xa    (SUM_W'(root)),
      .angle (pitch_c)
   );

   // align roll and yaw with the longer pitch path, carry clamp bits beside pitch
   logic [2*OUT_W-1:0] ry_ff [0:DLY-1];
   logic [1:0]         cl_ff [0:CLAT-1];

   always_ff @(posedge clock) begin
      if (advance) begin
         ry_ff[0] <= {roll_c, yaw_c};
         for (int i = 1; i < DLY; i++) ry_ff[i] <= ry_ff[i-1];
         cl_ff[0] <= {ps_sq.clamp_pos, ps_sq.clamp_neg};
         for (int i = 1; i < CLAT; i++) cl_ff[i] <= cl_ff[i-1];
      end
   end

   // drive the result
   assign rsp_valid         = vld_ff[LAT-1];
   assign rsp_roll_angle    = ry_ff[DLY-1][2*OUT_W-1:OUT_W];
   assign rsp_yaw_angle     = ry_ff[DLY-1][OUT_W-1:0];
   assign rsp_pitch_clamped = cl_ff[CLAT-1][1] | cl_ff[CLAT-1][0];

   always_comb begin
      if (cl_ff[CLAT-1][1])
         rsp_pitch_angle = 15'(HALF_PI_Q13);
      else if (cl_ff[CLAT-1][0])
         rsp_pitch_angle = -15'(HALF_PI_Q13);
      else
         rsp_pitch_angle = pitch_c[14:0];
   end

   // checks
   a_stall_only_on_held_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pitch_clamped) |->
         (rsp_pitch_angle == 15'sd12868 || rsp_pitch_angle == -15'sd12868))
      else $error("clamped pitch not at a pole");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= 15'sd12868 && rsp_pitch_angle >= -15'sd12868))
      else $error("pitch out of range");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_angle <= 16'sd25736 && rsp_roll_angle >= -16'sd25736))
      else $error("roll out of range");

endmodule

### rtl/core/qte_isqrt.sv
module qte_isqrt import qte_pkg::*; (
   input  logic           clock,
   input  logic           en,
   input  rad_type        rad,
   input  pitch_side_type side_in,
   output root_type       root,
   output pitch_side_type side_out
);

   localparam int TW = RAD_W + 1;

   rad_type        rem_ff  [0:ROOT_W-1];
   root_type       root_ff [0:ROOT_W-1];
   pitch_side_type side_ff [0:ROOT_W-1];

   rad_type        rem_s  [0:ROOT_W];
   root_type       root_s [0:ROOT_W];
   pitch_side_type side_s [0:ROOT_W];

   assign rem_s[0]  = rad;
   assign root_s[0] = '0;
   assign side_s[0] = side_in;

   // one result bit per stage, most significant first
   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      localparam int K = ROOT_W - 1 - s;
      logic [TW-1:0] trial;
      logic          take;
      rad_type       rem_in;
      root_type      root_in;

      always_comb begin
         trial = (TW'(root_s[s]) << (K + 1)) | (TW'(1) << (2 * K));
         take  = {1'b0, rem_s[s]} >= trial;
         if (take) begin
            rem_in  = RAD_W'({1'b0, rem_s[s]} - trial);
            root_in = root_s[s] | (root_type'(1) << K);
         end else begin
            rem_in  = rem_s[s];
            root_in = root_s[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            side_ff[s] <= side_s[s];
         end
      end

      assign rem_s[s+1]  = rem_ff[s];
      assign root_s[s+1] = root_ff[s];
      assign side_s[s+1] = side_ff[s];
   end

   assign root     = root_s[ROOT_W];
   assign side_out = side_s[ROOT_W];

endmodule

### rtl/core/qte_cordic.sv
module qte_cordic import qte_pkg::*; #(
   parameter int ITER = 16,
   parameter int LIM  = 25736
) (
   input  logic      clock,
   input  logic      en,
   input  sum_type   ya,
   input  sum_type   xa,
   output angle_type angle
);

   localparam int RW = ANG_W - 11;

   vec_type   xv_ff   [0:ITER];
   vec_type   yv_ff   [0:ITER];
   ang_type   ang_ff  [0:ITER];
   logic      zero_ff [0:ITER];
   angle_type angle_ff;

   // fold the left half plane onto the right one
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (xa == '0) && (ya == '0);
         if (xa < 0) begin
            xv_ff[0]  <= -VEC_W'(xa);
            yv_ff[0]  <= -VEC_W'(ya);
            ang_ff[0] <= (ya >= 0) ? PI_Q24 : -PI_Q24;
         end else begin
            xv_ff[0]  <= VEC_W'(xa);
            yv_ff[0]  <= VEC_W'(ya);
            ang_ff[0] <= '0;
         end
      end
   end

   // one vectoring rotation per stage
   for (genvar i = 0; i < ITER; i++) begin : g_iter
      vec_type dx, dy;
      assign dx = yv_ff[i] >>> i;
      assign dy = xv_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (yv_ff[i] > 0) begin
               xv_ff[i+1]  <= xv_ff[i] + dx;
               yv_ff[i+1]  <= yv_ff[i] - dy;
               ang_ff[i+1] <= ang_ff[i] + atan_entry(i);
            end else begin
               xv_ff[i+1]  <= xv_ff[i] - dx;
               yv_ff[i+1]  <= yv_ff[i] + dy;
               ang_ff[i+1] <= ang_ff[i] - atan_entry(i);
            end
         end
      end
   end

   // round to Q3.13 and saturate
   ang_type                ang_rnd;
   logic signed [RW-1:0]   ang_q13;
   angle_type              angle_in;

   always_comb begin
      ang_rnd = ang_ff[ITER] + ang_type'(1024);
      ang_q13 = RW'(ang_rnd >>> 11);
      if (zero_ff[ITER])
         angle_in = '0;
      else if (ang_q13 > RW'(LIM))
         angle_in = OUT_W'(LIM);
      else if (ang_q13 < -RW'(LIM))
         angle_in = -OUT_W'(LIM);
      else
         angle_in = OUT_W'(ang_q13);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

### bench/tb_top.sv
// Predicts the Euler angles of each quaternion and checks the block's results in order.
class euler_scoreboard;
   localparam int ITER   = 16;
   localparam longint ONE_Q30 = 64'sd1 << 30;
   localparam longint PI_Q24  = 64'sd52707179;

   typedef struct {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
      logic               clamped;
   } angles_type;

   angles_type expected_angles[$];
   int      mismatch_count;
   longint  atan_step[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
      262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2};

   // floor square root of a non-negative value
   function automatic longint floor_sqrt(longint v);
      longint lo, hi, mid;
      lo = 0;
      hi = 64'sd1 << 31;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (mid * mid <= v) lo = mid;
         else hi = mid;
      end
      return lo;
   endfunction

   // vectoring CORDIC; angle at scale 2^24 (>>> on longint is a floor shift)
   function automatic longint vector_angle(longint ya, longint xa);
      longint xv, yv, ang, dx, dy;
      xv = xa;
      yv = ya;
      ang = 0;
      if (xa == 0 && ya == 0) return 0;
      if (xa < 0) begin
         xv = -xa;
         yv = -ya;
         ang = (ya >= 0) ? PI_Q24 : -PI_Q24;
      end
      for (int i = 0; i < ITER && i < 24; i++) begin
         dx = yv >>> i;
         dy = xv >>> i;
         if (yv > 0) begin
            xv += dx; yv -= dy; ang += atan_step[i];
         end else begin
            xv -= dx; yv += dy; ang -= atan_step[i];
         end
      end
      return ang;
   endfunction

   function automatic longint round_q13(longint a, longint lim);
      longint r;
      r = (a + 1024) >>> 11;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   // note one accepted quaternion
   function void note_quaternion(logic signed [15:0] qw, logic signed [15:0] qx,
                                 logic signed [15:0] qy, logic signed [15:0] qz);
      longint w, x, y, z, sr, cr, sp, sy, cy, c;
      angles_type e;
      w = qw; x = qx; y = qy; z = qz;
      sr = 2 * (w * x + y * z);
      cr = ONE_Q30 - 2 * (x * x + y * y);
      sp = 2 * (w * y - z * x);
      sy = 2 * (w * z + x * y);
      cy = ONE_Q30 - 2 * (y * y + z * z);
      e.roll = 16'(round_q13(vector_angle(sr, cr), 25736));
      e.yaw  = 16'(round_q13(vector_angle(sy, cy), 25736));
      e.clamped = 1'b0;
      if (sp >= ONE_Q30) begin
         e.pitch = 15'sd12868; e.clamped = 1'b1;
      end else if (sp <= -ONE_Q30) begin
         e.pitch = -15'sd12868; e.clamped = 1'b1;
      end else begin
         c = floor_sqrt((64'sd1 << 60) - sp * sp);
         e.pitch = 15'(round_q13(vector_angle(sp, c), 12868));
      end
      expected_angles.push_back(e);
   endfunction

   // check one result against the oldest expectation
   function void check_angles(logic signed [15:0] roll, logic signed [14:0] pitch,
                              logic signed [15:0] yaw, logic clamped);
      angles_type e;
      if (expected_angles.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("unexpected result roll=%0d", roll);
         return;
      end
      e = expected_angles.pop_front();
      if (roll !== e.roll || pitch !== e.pitch || yaw !== e.yaw || clamped !== e.clamped)
      begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch: exp r=%0d p=%0d y=%0d c=%0b got r=%0d p=%0d y=%0d c=%0b",
                     e.roll, e.pitch, e.yaw, e.clamped, roll, pitch, yaw, clamped);
      end
   endfunction
endclass

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 53;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_roll_angle, rsp_yaw_angle;
   logic signed [14:0] rsp_pitch_angle;
   logic rsp_pitch_clamped;

   euler_scoreboard board = new();
   int  sender_idle_pct = 0;
   int  receiver_stall_pct = 0;
   bit  hold_off = 1'b0;
   bit  done = 1'b0;
   int  quiet_cycles = 0;

   quaternion_to_euler_angles u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // drive stall; a hold-off keeps the output stalled for a long stretch
   always @(posedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // check results and watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_angles(rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle,
                               rsp_pitch_clamped);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || done)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // offer one quaternion, idling first at random, and wait for its transfer
   task automatic send_quaternion(logic signed [15:0] w, logic signed [15:0] x,
                                  logic signed [15:0] y, logic signed [15:0] z);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_quat_w <= w; req_quat_x <= x; req_quat_y <= y; req_quat_z <= z;
      do @(posedge clock); while (req_stall);
      board.note_quaternion(w, x, y, z);
   endtask

   task automatic wait_drained();
      while (board.expected_angles.size() != 0) @(posedge clock);
   endtask

   // random quaternion: mostly near unit length, some raw noise, some near gimbal lock
   task automatic send_random();
      int kind;
      real a, b, c, d, n;
      kind = $urandom_range(9);
      if (kind < 2) begin
         send_quaternion(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (kind < 3) begin
         int s;
         s = $urandom_range(1) ? 23170 : -23170;
         send_quaternion(16'(s + $signed($urandom_range(8)) - 4),
                         16'($signed($urandom_range(600)) - 300), 16'sd23170, 16'(-s));
      end else begin
         a = $itor($signed($urandom_range(2000))) - 1000.0;
         b = $itor($signed($urandom_range(2000))) - 1000.0;
         c = $itor($signed($urandom_range(2000))) - 1000.0;
         d = $itor($signed($urandom_range(2000))) - 1000.0;
         n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
         send_quaternion(16'($rtoi(a / n * 32767.0)), 16'($rtoi(b / n * 32767.0)),
                         16'($rtoi(c / n * 32767.0)), 16'($rtoi(d / n * 32767.0)));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity, extremes, clamp at the positive pole, atan2 on the negative axis
      send_quaternion(32767, 0, 0, 0);
      send_quaternion(0, 0, 0, 0);
      send_quaternion(-32768, -32768, -32768, -32768);
      send_quaternion(32767, 32767, 32767, 32767);
      send_quaternion(-32768, 32767, -32768, 32767);
      send_quaternion(0, 32767, 0, 0);
      send_quaternion(0, 0, 32767, 0);
      send_quaternion(0, 0, 0, 32767);
      send_quaternion(0, -32768, 0, 0);
      send_quaternion(23170, 0, 23170, 0);
      send_quaternion(23170, 0, -23170, 0);
      send_quaternion(23170, 0, 23171, 0);
      send_quaternion(23170, 23170, 0, 0);
      send_quaternion(23170, -23170, 0, 0);
      send_quaternion(23170, 0, 0, -23170);
      send_quaternion(16384, 16384, 16384, -16384);
      send_quaternion(-1, 1, -1, 1);
      send_quaternion(16'h5555, 16'shaaaa, 16'h5555, 16'shaaaa);

      // pause until the pipeline drains
      req_valid <= 1'b0;
      wait_drained();

      // long hold-off on the output while inputs keep coming
      hold_off = 1'b1;
      fork
         repeat (100) send_random();
         begin
            repeat (150) @(posedge clock);
            hold_off = 1'b0;
         end
      join

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 49; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 49; end
            default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
         endcase
         repeat (125) send_random();
      end
      req_valid <= 1'b0;
      receiver_stall_pct = 0;
      wait_drained();
      done = 1'b1;
      repeat (LATENCY + 10) @(posedge clock);

      if (board.mismatch_count == 0 && board.expected_angles.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
